/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file rvexu_port_check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define AM_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Next-cycle implication, checked during reset too.
`define AM_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

/* rtl/core/rvexu_pkg.sv */
package rvexu_pkg;

  localparam logic [2:0] ST_RETIRED = 3'd0;
  localparam logic [2:0] ST_READ    = 3'd1;
  localparam logic [2:0] ST_WRITE   = 3'd2;
  localparam logic [2:0] ST_TRAP    = 3'd3;
  localparam logic [2:0] ST_ILLEGAL = 3'd4;
  localparam logic [2:0] ST_UNEXP   = 3'd5;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // ALU funct3
  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SLL  = 3'd1;
  localparam logic [2:0] ALU_SLT  = 3'd2;
  localparam logic [2:0] ALU_SLTU = 3'd3;
  localparam logic [2:0] ALU_XOR  = 3'd4;
  localparam logic [2:0] ALU_SR   = 3'd5;
  localparam logic [2:0] ALU_OR   = 3'd6;
  localparam logic [2:0] ALU_AND  = 3'd7;

  // multiply funct3
  localparam logic [2:0] MD_MUL  = 3'd0;
  localparam logic [2:0] MD_MULH = 3'd1;

  // load and store funct3
  localparam logic [2:0] LD_B  = 3'd0;
  localparam logic [2:0] LD_H  = 3'd1;
  localparam logic [2:0] LD_W  = 3'd2;
  localparam logic [2:0] LD_BU = 3'd4;
  localparam logic [2:0] LD_HU = 3'd5;
  localparam logic [2:0] SD_B  = 3'd0;
  localparam logic [2:0] SD_H  = 3'd1;
  localparam logic [2:0] SD_W  = 3'd2;

  // branch funct3
  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  localparam logic [2:0] JALR_FN = 3'd0;

  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
  localparam logic [4:0]  REG_A0 = 5'd10;
  localparam logic [31:0] RESET_PC = 32'h8000_0000;

  typedef struct packed {
    logic accept;
    logic exec;
    logic div_start;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic ignore;
    logic is_div;
    logic div_done;
  } sts_t;

endpackage

/* rtl/core/rvexu_regfile.sv */
module rvexu_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [31:0] wdata,
  input  logic        re,
  input  logic [4:0]  raddr1,
  input  logic [4:0]  raddr2,
  output logic [31:0] rdata1,
  output logic [31:0] rdata2
);

  logic [31:0] mem [32];
  logic [31:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Unwritten entries read as zero.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata1 <= valid[raddr1] ? mem[raddr1] : '0;
      rdata2 <= valid[raddr2] ? mem[raddr2] : '0;
    end
  end

endmodule

/* rtl/core/rvexu_div.sv */
module rvexu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  logic        sgn,
  input  logic        rem_sel,
  output logic        done,
  output logic [31:0] result
);

  logic        busy;
  logic        fin;
  logic [4:0]  cnt;
  logic [31:0] q;
  logic [31:0] r;
  logic [31:0] d;
  logic        neg_q;
  logic        neg_r;
  logic        zero_div;
  logic        rem_keep;
  logic [31:0] a_keep;
  logic [32:0] r_sh;
  logic [33:0] diff;
  logic [31:0] na;
  logic [31:0] nb;

  assign na = (sgn && dividend[31]) ? (32'd0 - dividend) : dividend;
  assign nb = (sgn && divisor[31]) ? (32'd0 - divisor) : divisor;
  assign r_sh = {r, q[31]};
  assign diff = {1'b0, r_sh} - {2'b00, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      fin  <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  // One restoring step per cycle on magnitudes.
  always_ff @(posedge clk) begin
    if (start) begin
      q        <= na;
      r        <= '0;
      d        <= nb;
      neg_q    <= sgn && (dividend[31] ^ divisor[31]);
      neg_r    <= sgn && dividend[31];
      zero_div <= (divisor == 32'd0);
      rem_keep <= rem_sel;
      a_keep   <= dividend;
    end else if (busy) begin
      if (!diff[33]) begin
        r <= diff[31:0];
        q <= {q[30:0], 1'b1};
      end else begin
        r <= r_sh[31:0];
        q <= {q[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (zero_div) begin
      result = rem_keep ? a_keep : '1;
    end else if (rem_keep) begin
      result = neg_r ? (32'd0 - r) : r;
    end else begin
      result = neg_q ? (32'd0 - q) : q;
    end
  end

  assign done = fin;

endmodule

/* rtl/core/rvexu_datapath.sv */
module rvexu_datapath (
  input  logic             clk,
  input  logic             rst,
  input  rvexu_pkg::ctl_t  ctl,
  output rvexu_pkg::sts_t  sts,
  input  logic             kind,
  input  logic [31:0]      instr,
  input  logic [31:0]      load_data,
  input  logic             reset_pc_we,
  input  logic [31:0]      reset_pc_wdata,
  output logic [2:0]       status,
  output logic [31:0]      inst_pc,
  output logic [31:0]      next_pc,
  output logic [31:0]      mem_addr,
  output logic [1:0]       mem_size,
  output logic [31:0]      mem_wdata,
  output logic [31:0]      trap_value
);

  logic        ir_kind;
  logic [31:0] ir;
  logic [31:0] ld;
  logic [31:0] pc;
  logic        load_waiting;
  logic [4:0]  load_dest;
  logic [2:0]  load_format;
  logic [63:0] prod;
  logic [65:0] prod_full;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] div_res;

  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [4:0]  sh_i;

  logic [2:0]  d_status;
  logic [31:0] d_inst_pc;
  logic [31:0] d_next;
  logic [31:0] d_addr;
  logic [1:0]  d_size;
  logic [31:0] d_wdata;
  logic [31:0] d_trap;
  logic        d_wr;
  logic [4:0]  d_rd;
  logic [31:0] d_val;
  logic        d_is_mul;
  logic        d_is_div;
  logic        d_load_issue;
  logic        d_load_done;
  logic        take;
  logic [31:0] ext;

  rvexu_regfile u_rf (
    .clk    (clk),
    .rst    (rst),
    .we     (ctl.commit && d_wr && (d_rd != 5'd0)),
    .waddr  (d_rd),
    .wdata  (d_val),
    .re     (ctl.accept),
    .raddr1 ((instr == rvexu_pkg::EBREAK_WORD) ? rvexu_pkg::REG_A0 : instr[19:15]),
    .raddr2 (instr[24:20]),
    .rdata1 (a),
    .rdata2 (b)
  );

  rvexu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (a),
    .divisor  (b),
    .sgn      (!f3[0]),
    .rem_sel  (f3[1]),
    .done     (sts.div_done),
    .result   (div_res)
  );

  assign opc   = ir[6:0];
  assign rd    = ir[11:7];
  assign f3    = ir[14:12];
  assign f7    = ir[31:25];
  assign imm_i = {{20{ir[31]}}, ir[31:20]};
  assign imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
  assign imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
  assign imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
  assign sh_i  = ir[24:20];
  assign prod_full = $signed({a[31], a}) * $signed({b[31], b});

  always_comb begin
    unique case (load_format)
      rvexu_pkg::LD_B:  ext = {{24{ld[7]}}, ld[7:0]};
      rvexu_pkg::LD_H:  ext = {{16{ld[15]}}, ld[15:0]};
      rvexu_pkg::LD_BU: ext = {24'd0, ld[7:0]};
      rvexu_pkg::LD_HU: ext = {16'd0, ld[15:0]};
      default:          ext = ld;
    endcase
  end

  always_comb begin
    d_status     = rvexu_pkg::ST_RETIRED;
    d_inst_pc    = pc;
    d_next       = pc + 32'd4;
    d_addr       = '0;
    d_size       = '0;
    d_wdata      = '0;
    d_trap       = '0;
    d_wr         = 1'b0;
    d_rd         = rd;
    d_val        = '0;
    d_is_mul     = 1'b0;
    d_is_div     = 1'b0;
    d_load_issue = 1'b0;
    d_load_done  = 1'b0;
    take         = 1'b0;
    if (ir_kind) begin
      d_next = pc;
      if (!load_waiting) begin
        d_status = rvexu_pkg::ST_UNEXP;
      end else begin
        d_inst_pc   = pc - 32'd4;
        d_wr        = 1'b1;
        d_rd        = load_dest;
        d_val       = ext;
        d_load_done = 1'b1;
      end
    end else begin
      unique case (opc)
        rvexu_pkg::OP_REG: begin
          d_wr = 1'b1;
          if (f7 == rvexu_pkg::F7_BASE) begin
            unique case (f3)
              rvexu_pkg::ALU_ADD:  d_val = a + b;
              rvexu_pkg::ALU_SLL:  d_val = a << b[4:0];
              rvexu_pkg::ALU_SLT:  d_val = {31'd0, $signed(a) < $signed(b)};
              rvexu_pkg::ALU_SLTU: d_val = {31'd0, a < b};
              rvexu_pkg::ALU_XOR:  d_val = a ^ b;
              rvexu_pkg::ALU_SR:   d_val = a >> b[4:0];
              rvexu_pkg::ALU_OR:   d_val = a | b;
              default:             d_val = a & b;
            endcase
          end else if (f7 == rvexu_pkg::F7_ALT && f3 == rvexu_pkg::ALU_ADD) begin
            d_val = a - b;
          end else if (f7 == rvexu_pkg::F7_ALT && f3 == rvexu_pkg::ALU_SR) begin
            d_val = $unsigned($signed(a) >>> b[4:0]);
          end else if (f7 == rvexu_pkg::F7_MULDIV && f3 == rvexu_pkg::MD_MUL) begin
            d_is_mul = 1'b1;
            d_val    = prod[31:0];
          end else if (f7 == rvexu_pkg::F7_MULDIV && f3 == rvexu_pkg::MD_MULH) begin
            d_is_mul = 1'b1;
            d_val    = prod[63:32];
          end else if (f7 == rvexu_pkg::F7_MULDIV && f3[2]) begin
            d_is_div = 1'b1;
            d_val    = div_res;
          end else begin
            d_wr     = 1'b0;
            d_status = rvexu_pkg::ST_ILLEGAL;
          end
        end
        rvexu_pkg::OP_IMM: begin
          d_wr = 1'b1;
          unique case (f3)
            rvexu_pkg::ALU_ADD:  d_val = a + imm_i;
            rvexu_pkg::ALU_SLT:  d_val = {31'd0, $signed(a) < $signed(imm_i)};
            rvexu_pkg::ALU_SLTU: d_val = {31'd0, a < imm_i};
            rvexu_pkg::ALU_XOR:  d_val = a ^ imm_i;
            rvexu_pkg::ALU_OR:   d_val = a | imm_i;
            rvexu_pkg::ALU_AND:  d_val = a & imm_i;
            rvexu_pkg::ALU_SLL: begin
              if (f7 == rvexu_pkg::F7_BASE) begin
                d_val = a << sh_i;
              end else begin
                d_wr     = 1'b0;
                d_status = rvexu_pkg::ST_ILLEGAL;
              end
            end
            default: begin
              if (f7 == rvexu_pkg::F7_BASE) begin
                d_val = a >> sh_i;
              end else if (f7 == rvexu_pkg::F7_ALT) begin
                d_val = $unsigned($signed(a) >>> sh_i);
              end else begin
                d_wr     = 1'b0;
                d_status = rvexu_pkg::ST_ILLEGAL;
              end
            end
          endcase
        end
        rvexu_pkg::OP_LOAD: begin
          if (f3 != rvexu_pkg::LD_B && f3 != rvexu_pkg::LD_H && f3 != rvexu_pkg::LD_W &&
              f3 != rvexu_pkg::LD_BU && f3 != rvexu_pkg::LD_HU) begin
            d_status = rvexu_pkg::ST_ILLEGAL;
          end else begin
            d_status     = rvexu_pkg::ST_READ;
            d_addr       = a + imm_i;
            d_size       = f3[1:0];
            d_load_issue = 1'b1;
          end
        end
        rvexu_pkg::OP_STORE: begin
          if (f3 > rvexu_pkg::SD_W) begin
            d_status = rvexu_pkg::ST_ILLEGAL;
          end else begin
            d_status = rvexu_pkg::ST_WRITE;
            d_addr   = a + imm_s;
            d_size   = f3[1:0];
            d_wdata  = (f3 == rvexu_pkg::SD_B) ? {24'd0, b[7:0]} :
                       (f3 == rvexu_pkg::SD_H) ? {16'd0, b[15:0]} : b;
          end
        end
        rvexu_pkg::OP_JALR: begin
          if (f3 != rvexu_pkg::JALR_FN) begin
            d_status = rvexu_pkg::ST_ILLEGAL;
          end else begin
            d_wr   = 1'b1;
            d_val  = pc + 32'd4;
            d_next = (a + imm_i) & ~32'd1;
          end
        end
        rvexu_pkg::OP_AUIPC: begin
          d_wr  = 1'b1;
          d_val = pc + {ir[31:12], 12'd0};
        end
        rvexu_pkg::OP_LUI: begin
          d_wr  = 1'b1;
          d_val = {ir[31:12], 12'd0};
        end
        rvexu_pkg::OP_JAL: begin
          d_wr   = 1'b1;
          d_val  = pc + 32'd4;
          d_next = pc + imm_j;
        end
        rvexu_pkg::OP_BRANCH: begin
          unique case (f3)
            rvexu_pkg::BR_EQ:  take = (a == b);
            rvexu_pkg::BR_NE:  take = (a != b);
            rvexu_pkg::BR_LT:  take = $signed(a) < $signed(b);
            rvexu_pkg::BR_GE:  take = !($signed(a) < $signed(b));
            rvexu_pkg::BR_LTU: take = a < b;
            rvexu_pkg::BR_GEU: take = a >= b;
            default: d_status = rvexu_pkg::ST_ILLEGAL;
          endcase
          if (take) begin
            d_next = pc + imm_b;
          end
        end
        rvexu_pkg::OP_SYSTEM: begin
          if (ir == rvexu_pkg::EBREAK_WORD) begin
            d_status = rvexu_pkg::ST_TRAP;
            d_trap   = a;
          end else begin
            d_status = rvexu_pkg::ST_ILLEGAL;
          end
        end
        default: d_status = rvexu_pkg::ST_ILLEGAL;
      endcase
    end
  end

  assign sts.ignore = !ir_kind && load_waiting;
  assign sts.is_div = d_is_div;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      ir_kind <= kind;
      ir      <= instr;
      ld      <= load_data;
    end
    if (ctl.exec && d_is_mul) begin
      prod <= prod_full[63:0];
    end
    if (ctl.commit) begin
      status     <= d_status;
      inst_pc    <= d_inst_pc;
      next_pc    <= d_next;
      mem_addr   <= d_addr;
      mem_size   <= d_size;
      mem_wdata  <= d_wdata;
      trap_value <= d_trap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= rvexu_pkg::RESET_PC;
      load_waiting <= 1'b0;
      load_dest    <= '0;
      load_format  <= '0;
    end else if (reset_pc_we) begin
      pc <= reset_pc_wdata;
    end else if (ctl.commit) begin
      pc <= d_next;
      if (d_load_issue) begin
        load_waiting <= 1'b1;
        load_dest    <= rd;
        load_format  <= f3;
      end else if (d_load_done) begin
        load_waiting <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/rvexu_ctrl.sv */
module rvexu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rvexu_pkg::sts_t  sts,
  output rvexu_pkg::ctl_t  ctl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    ctl.accept    = 1'b0;
    ctl.exec      = 1'b0;
    ctl.div_start = 1'b0;
    ctl.commit    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.ignore) begin
          state_next = S_IDLE;
        end else if (sts.is_div) begin
          ctl.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/rv32im_execute_unit.sv */
// RV32IM execute unit.
// Input channel (in_valid/in_ready) carries one word: kind selects an
// instruction (instr) or the read data answering a pending load (load_data).
// Output channel (out_valid/out_ready) carries one result word per item:
// status, inst_pc, next_pc and the memory request fields or trap value.
// An instruction arriving while a load is pending is dropped with no result.
// Each item is accepted, executed and then committed into the output
// register; div/divu/rem/remu also pass through the radix-2 divider,
// which retires one quotient bit per cycle, between execute and commit.
// Items are handled one at a time, but in_ready rises again right after a
// result is loaded into the output register, so the next word is taken
// while the previous result still waits.
// If the receiver stalls, the finished result holds in the output register
// and the next result waits in the commit step until the register drains.
// Reset (rst, synchronous) sets the pc to 0x80000000 and clears the
// pending load, the output valid and the register file, whose entries
// read as zero until written. A write on reset_pc_we loads reset_pc_wdata
// straight into the pc; write it only while the unit is idle.
module rv32im_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] instr,
  input  logic [31:0] load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] inst_pc,
  output logic [31:0] next_pc,
  output logic [31:0] mem_addr,
  output logic [1:0]  mem_size,
  output logic [31:0] mem_wdata,
  output logic [31:0] trap_value,
  input  logic        reset_pc_we,
  input  logic [31:0] reset_pc_wdata
);

  rvexu_pkg::ctl_t ctl;
  rvexu_pkg::sts_t sts;

  // Sequence accept, execute, divide and commit.
  rvexu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Hold architectural state, decode and compute.
  rvexu_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .kind           (kind),
    .instr          (instr),
    .load_data      (load_data),
    .reset_pc_we    (reset_pc_we),
    .reset_pc_wdata (reset_pc_wdata),
    .status         (status),
    .inst_pc        (inst_pc),
    .next_pc        (next_pc),
    .mem_addr       (mem_addr),
    .mem_size       (mem_size),
    .mem_wdata      (mem_wdata),
    .trap_value     (trap_value)
  );

endmodule

/* rtl/core/rvexu_port_check.sv */
`include "assert_macros.svh"

module rvexu_port_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic [2:0]  status,
  input logic [31:0] mem_addr,
  input logic [31:0] mem_wdata,
  input logic [31:0] trap_value
);

  `AM_NEXT(a_reset_clears, clk, rst, !out_valid)
  `AM_IMPLY(a_status_range, clk, rst, out_valid, status <= rvexu_pkg::ST_UNEXP)
  `AM_IMPLY(a_wdata_store, clk, rst, out_valid && status != rvexu_pkg::ST_WRITE, mem_wdata == 32'd0)
  `AM_IMPLY(a_trap_only, clk, rst, out_valid && status != rvexu_pkg::ST_TRAP, trap_value == 32'd0)
  `AM_IMPLY(a_addr_mem, clk, rst, out_valid && status != rvexu_pkg::ST_READ && status != rvexu_pkg::ST_WRITE, mem_addr == 32'd0)

endmodule

bind rv32im_execute_unit rvexu_port_check u_port_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .status     (status),
  .mem_addr   (mem_addr),
  .mem_wdata  (mem_wdata),
  .trap_value (trap_value)
);
